[rtl/sprite_quad_vertex_generator_unit_defines.svh]
// ----------------------------------------------------------------------------
// Sprite quad vertex generator assertion macros
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SQVG_ASSERT(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);
`define SQVG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SQVG_ASSERT(name, cond, msg)
`define SQVG_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

[rtl/sqvg_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite quad vertex generator package
// Word types, pipeline control struct, constants and table helpers.
// ----------------------------------------------------------------------------
package sqvg_pkg;

    localparam int MAX_TEXTURE_DIM_DEF  = 4096;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam int CFG_W      = 13;
    localparam int SCW        = 17;
    localparam int QW         = 16;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = 4;
    localparam int GW         = 49;
    localparam int ROUND_Q8   = 128;
    localparam int ROUND_Q15  = 16384;

    localparam logic [16:0]        TEX_ONE  = 17'h10000;
    localparam logic [16:0]        TEX_ZERO = 17'h00000;
    localparam logic signed [31:0] POS_MAX  = 32'sh7fffffff;
    localparam logic signed [31:0] POS_MIN  = 32'sh80000000;

    localparam logic [2:0] FIRST_K = 3'd0;
    localparam logic [2:0] LAST_K  = 3'd5;

    localparam logic REG_TEX_W = 1'b0;
    localparam logic REG_TEX_H = 1'b1;

    localparam longint POLY_C1 = 64'sd1686629713;
    localparam longint POLY_C3 = 64'sd693598669;
    localparam longint POLY_C5 = 64'sd85569306;
    localparam longint POLY_C7 = 64'sd5026995;
    localparam longint POLY_C9 = 64'sd172272;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint Q15_ONE = 64'sd32768;

    typedef struct packed {
        logic [12:0]        src_x;
        logic [12:0]        src_y;
        logic [12:0]        src_w;
        logic [12:0]        src_h;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic [15:0]        angle;
        logic [1:0]         orientation;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [2:0]         vertex_index;
        logic               last_vertex;
    } out_word_t;

    typedef struct packed {
        logic s2_load;
        logic s3_load;
        logic s4_load;
        logic s5_load;
    } stage_ctl_t;

    function automatic longint quarter_sine(input longint t);
        longint t2;
        longint acc;
        t2  = (t * t) >>> 30;
        acc = POLY_C9;
        acc = -POLY_C7 + ((acc * t2) >>> 30);
        acc = POLY_C5 + ((acc * t2) >>> 30);
        acc = -POLY_C3 + ((acc * t2) >>> 30);
        acc = POLY_C1 + ((acc * t2) >>> 30);
        acc = (acc * t) >>> 30;
        acc = (acc + longint'(ROUND_Q15)) >>> 15;
        if (acc > Q15_ONE) acc = Q15_ONE;
        if (acc < 0) acc = 0;
        return acc;
    endfunction

    function automatic longint sin_quad(input int q, input longint a, input longint b);
        case (q)
            0:       return a;
            1:       return b;
            2:       return -a;
            default: return -b;
        endcase
    endfunction

    function automatic longint cos_quad(input int q, input longint a, input longint b);
        case (q)
            0:       return b;
            1:       return -a;
            2:       return -b;
            default: return a;
        endcase
    endfunction

    // corner code: bit0 right, bit1 bottom
    function automatic logic [1:0] corner_of(input logic [2:0] k);
        case (k)
            3'd0:    return 2'd0;
            3'd1:    return 2'd2;
            3'd2:    return 2'd1;
            3'd3:    return 2'd1;
            3'd4:    return 2'd2;
            3'd5:    return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

endpackage

[rtl/sqvg_div.sv]
// ----------------------------------------------------------------------------
// Texture coordinate divider
// Restoring division of n * 65536 + size / 2 by size over four stages.
// ----------------------------------------------------------------------------
module sqvg_div #(
    parameter int DW = 13
) (
    input  logic                 aclk,
    input  sqvg_pkg::stage_ctl_t ctl,
    input  logic                 in_zero,
    input  logic                 in_big,
    input  logic [DW-1:0]        in_n,
    input  logic [DW-1:0]        in_size,
    output logic [16:0]          coord
);
    import sqvg_pkg::*;

    logic [DIV_STAGES-1:0] load;
    logic [DW-1:0]         rem_reg  [DIV_STAGES];
    logic [QW-1:0]         q_reg    [DIV_STAGES];
    logic [DW-1:0]         size_reg [DIV_STAGES];
    logic                  zero_reg [DIV_STAGES];
    logic                  big_reg  [DIV_STAGES];

    assign load = {ctl.s5_load, ctl.s4_load, ctl.s3_load, ctl.s2_load};

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] size_in;
        logic          zero_in;
        logic          big_in;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign rem_in  = in_n;
            assign q_in    = '0;
            assign size_in = in_size;
            assign zero_in = in_zero;
            assign big_in  = in_big;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign size_in = size_reg[j-1];
            assign zero_in = zero_reg[j-1];
            assign big_in  = big_reg[j-1];
        end

        always_comb begin : step_comb
            logic [DW:0]   trial;
            logic [QW-1:0] half;
            half     = QW'(size_in >> 1);
            rem_next = rem_in;
            q_next   = q_in;
            for (int b = 0; b < DIV_STEPS; b++) begin
                trial = {rem_next, half[QW-1-(DIV_STEPS*j+b)]};
                if (trial >= {1'b0, size_in}) begin
                    rem_next = DW'(trial - {1'b0, size_in});
                    q_next[QW-1-(DIV_STEPS*j+b)] = 1'b1;
                end else begin
                    rem_next = trial[DW-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (load[j]) begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                size_reg[j] <= size_in;
                zero_reg[j] <= zero_in;
                big_reg[j]  <= big_in;
            end
        end
    end

    assign coord = zero_reg[DIV_STAGES-1] ? TEX_ZERO :
                   big_reg[DIV_STAGES-1]  ? TEX_ONE  : {1'b0, q_reg[DIV_STAGES-1]};

endmodule

[rtl/sqvg_xform.sv]
// ----------------------------------------------------------------------------
// Corner transform
// Offset, rotate and translate one corner; saturate to signed Q16.16.
// ----------------------------------------------------------------------------
module sqvg_xform #(
    parameter int WW = 29
) (
    input  logic                           aclk,
    input  sqvg_pkg::stage_ctl_t           ctl,
    input  logic [WW-1:0]                  in_wsx,
    input  logic [WW-1:0]                  in_hsy,
    input  logic signed [sqvg_pkg::GW-1:0] in_gxs,
    input  logic signed [sqvg_pkg::GW-1:0] in_gys,
    input  logic signed [31:0]             in_px,
    input  logic signed [31:0]             in_py,
    input  logic signed [sqvg_pkg::SCW-1:0] in_sin,
    input  logic signed [sqvg_pkg::SCW-1:0] in_cos,
    output logic signed [31:0]             vx,
    output logic signed [31:0]             vy
);
    import sqvg_pkg::*;

    localparam int CXW = (((WW + 9) > (GW - 6)) ? (WW + 9) : (GW - 6)) + 1;
    localparam int PW  = CXW + SCW;
    localparam int SW  = PW + 1;
    localparam int XW  = SW - 15;

    function automatic logic signed [31:0] sat32(input logic signed [XW:0] v);
        logic [XW-31:0] hi;
        hi = v[XW:31];
        if ((&hi) || !(|hi)) return v[31:0];
        return v[XW] ? POS_MIN : POS_MAX;
    endfunction

    logic signed [GW:0]     offx_full, offy_full;
    logic signed [CXW-1:0]  cx_next, cy_next, cx_reg, cy_reg;
    logic signed [SCW-1:0]  sin_s2_reg, cos_s2_reg;
    logic signed [31:0]     px_s2_reg, py_s2_reg, px_s3_reg, py_s3_reg, px_s4_reg, py_s4_reg;
    logic signed [PW-1:0]   pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [SW-1:0]   xsum, ysum;
    logic signed [XW-1:0]   xr_next, yr_next, xr_reg, yr_reg;
    logic signed [XW:0]     px_sum, py_sum;
    logic signed [31:0]     vx_next, vy_next, vx_reg, vy_reg;

    always_comb begin
        offx_full = (GW+1)'(ROUND_Q8) - (GW+1)'(in_gxs);
        offy_full = (GW+1)'(ROUND_Q8) - (GW+1)'(in_gys);
        cx_next   = CXW'(offx_full >>> 8) + signed'(CXW'({in_wsx, 8'd0}));
        cy_next   = CXW'(offy_full >>> 8) + signed'(CXW'({in_hsy, 8'd0}));
        xsum      = SW'(pxc_reg) - SW'(pys_reg) + SW'(ROUND_Q15);
        ysum      = SW'(pxs_reg) + SW'(pyc_reg) + SW'(ROUND_Q15);
        xr_next   = XW'(xsum >>> 15);
        yr_next   = XW'(ysum >>> 15);
        px_sum    = (XW+1)'(px_s4_reg) + (XW+1)'(xr_reg);
        py_sum    = (XW+1)'(py_s4_reg) + (XW+1)'(yr_reg);
        vx_next   = sat32(px_sum);
        vy_next   = sat32(py_sum);
    end

    always_ff @(posedge aclk) begin
        if (ctl.s2_load) begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            sin_s2_reg <= in_sin;
            cos_s2_reg <= in_cos;
            px_s2_reg  <= in_px;
            py_s2_reg  <= in_py;
        end
        if (ctl.s3_load) begin
            pxc_reg   <= cx_reg * cos_s2_reg;
            pys_reg   <= cy_reg * sin_s2_reg;
            pxs_reg   <= cx_reg * sin_s2_reg;
            pyc_reg   <= cy_reg * cos_s2_reg;
            px_s3_reg <= px_s2_reg;
            py_s3_reg <= py_s2_reg;
        end
        if (ctl.s4_load) begin
            xr_reg    <= xr_next;
            yr_reg    <= yr_next;
            px_s4_reg <= px_s3_reg;
            py_s4_reg <= py_s3_reg;
        end
        if (ctl.s5_load) begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;

endmodule

[rtl/sprite_quad_vertex_generator_unit.sv]
// ----------------------------------------------------------------------------
// Sprite quad vertex generator
// Six pipeline stages; one vertex word enters per cycle unless m_ready stalls
// the pipeline, and a new sprite may enter behind earlier vertices still in it.
// The sprite is accepted with its sixth vertex; words leave from the sixth stage.
// Synchronous reset clears the pipeline and sets both texture sizes to 1.
// ----------------------------------------------------------------------------
`include "sprite_quad_vertex_generator_unit_defines.svh"

module sprite_quad_vertex_generator_unit #(
    parameter int MAX_TEXTURE_DIM  = sqvg_pkg::MAX_TEXTURE_DIM_DEF,
    parameter int SINE_TABLE_DEPTH = sqvg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sqvg_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sqvg_pkg::out_word_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sqvg_pkg::*;

    localparam int DW  = $clog2(MAX_TEXTURE_DIM + 1);
    localparam int RW  = (DW > CFG_W) ? DW : CFG_W;
    localparam int WW  = RW + 16;
    localparam int IW  = $clog2(SINE_TABLE_DEPTH);
    localparam int NST = 6;

    logic [CFG_W-1:0] tex_w_reg, tex_h_reg;
    logic             cfg_wr;
    logic [DW-1:0]    tw_eff, th_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_w_reg <= CFG_W'(1);
            tex_h_reg <= CFG_W'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TEX_W: tex_w_reg <= pwdata[CFG_W-1:0];
                REG_TEX_H: tex_h_reg <= pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEX_W: prdata = 32'(tex_w_reg);
            REG_TEX_H: prdata = 32'(tex_h_reg);
            default:   prdata = '0;
        endcase
        if (tex_w_reg == '0) tw_eff = DW'(1);
        else if (RW'(tex_w_reg) > RW'(MAX_TEXTURE_DIM)) tw_eff = DW'(MAX_TEXTURE_DIM);
        else tw_eff = DW'(tex_w_reg);
        if (tex_h_reg == '0) th_eff = DW'(1);
        else if (RW'(tex_h_reg) > RW'(MAX_TEXTURE_DIM)) th_eff = DW'(MAX_TEXTURE_DIM);
        else th_eff = DW'(tex_h_reg);
    end

    logic [NST-1:0] vld_reg, vld_shift, load;
    stage_ctl_t     ctl;
    logic [2:0]     seq_k_reg;
    logic [2:0]     k_reg [NST-1];

    always_comb begin
        load[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign vld_shift = {vld_reg[NST-2:0], s_valid};
    assign ctl       = '{s2_load: load[1], s3_load: load[2], s4_load: load[3],
                         s5_load: load[4]};
    assign s_ready   = load[0] && (seq_k_reg == LAST_K);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            seq_k_reg <= FIRST_K;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (load[i]) vld_reg[i] <= vld_shift[i];
            end
            if (s_valid && load[0]) begin
                seq_k_reg <= (seq_k_reg == LAST_K) ? FIRST_K : seq_k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) k_reg[0] <= seq_k_reg;
        for (int i = 1; i < NST - 1; i++) begin
            if (load[i]) k_reg[i] <= k_reg[i-1];
        end
    end

    logic signed [SCW-1:0] sin_tab [SINE_TABLE_DEPTH];
    logic signed [SCW-1:0] cos_tab [SINE_TABLE_DEPTH];
    logic [IW-1:0]         sin_idx;

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
        localparam longint FOUR = 4 * g;
        localparam longint QD   = FOUR / SINE_TABLE_DEPTH;
        localparam longint RM   = FOUR - QD * SINE_TABLE_DEPTH;
        localparam longint TT   = (RM <<< 30) / SINE_TABLE_DEPTH;
        localparam longint A    = quarter_sine(TT);
        localparam longint B    = quarter_sine(ONE_Q30 - TT);
        localparam int     QM   = int'(QD & 3);
        localparam longint SN   = sin_quad(QM, A, B);
        localparam longint CS   = cos_quad(QM, A, B);
        assign sin_tab[g] = SCW'(SN);
        assign cos_tab[g] = SCW'(CS);
    end

    assign sin_idx = IW'((32'(s_data.angle) * 32'(SINE_TABLE_DEPTH)) >> 16);

    logic [1:0]            corner;
    logic                  whole, use_r, use_b;
    logic [RW-1:0]         rx_sel, ry_sel, rw_sel, rh_sel;
    logic [RW:0]           mu, mv, nu, nv;
    logic [WW-1:0]         s1_wsx_next, s1_hsy_next, s1_wsx_reg, s1_hsy_reg;
    logic signed [GW-1:0]  s1_gxs_next, s1_gys_next, s1_gxs_reg, s1_gys_reg;
    logic signed [31:0]    s1_px_reg, s1_py_reg;
    logic signed [SCW-1:0] s1_sin_reg, s1_cos_reg;
    logic                  s1_u_zero_next, s1_u_big_next, s1_v_zero_next, s1_v_big_next;
    logic                  s1_u_zero_reg, s1_u_big_reg, s1_v_zero_reg, s1_v_big_reg;
    logic [DW-1:0]         s1_u_n_reg, s1_v_n_reg, s1_tw_reg, s1_th_reg;

    always_comb begin
        corner = corner_of(seq_k_reg);
        whole  = (s_data.src_x == '0) && (s_data.src_y == '0) &&
                 (s_data.src_w == '0) && (s_data.src_h == '0);
        rx_sel = RW'(s_data.src_x);
        ry_sel = RW'(s_data.src_y);
        rw_sel = whole ? RW'(tw_eff) : RW'(s_data.src_w);
        rh_sel = whole ? RW'(th_eff) : RW'(s_data.src_h);
        use_r  = corner[0] ^ s_data.orientation[0];
        use_b  = corner[1] ^ s_data.orientation[1];
        mu     = use_r ? (RW+1)'(rx_sel) + (RW+1)'(rw_sel) : (RW+1)'(rx_sel) + (RW+1)'(2);
        mv     = use_b ? (RW+1)'(ry_sel) + (RW+1)'(rh_sel) : (RW+1)'(ry_sel) + (RW+1)'(2);
        nu     = mu - (RW+1)'(1);
        nv     = mv - (RW+1)'(1);
        s1_u_zero_next = mu <= (RW+1)'(1);
        s1_v_zero_next = mv <= (RW+1)'(1);
        s1_u_big_next  = nu >= (RW+1)'(tw_eff);
        s1_v_big_next  = nv >= (RW+1)'(th_eff);
        s1_wsx_next = corner[0] ? WW'(rw_sel) * WW'(s_data.scale_x) : '0;
        s1_hsy_next = corner[1] ? WW'(rh_sel) * WW'(s_data.scale_y) : '0;
        s1_gxs_next = GW'(s_data.origin_x) * GW'(signed'({1'b0, s_data.scale_x}));
        s1_gys_next = GW'(s_data.origin_y) * GW'(signed'({1'b0, s_data.scale_y}));
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            s1_wsx_reg    <= s1_wsx_next;
            s1_hsy_reg    <= s1_hsy_next;
            s1_gxs_reg    <= s1_gxs_next;
            s1_gys_reg    <= s1_gys_next;
            s1_px_reg     <= s_data.pos_x;
            s1_py_reg     <= s_data.pos_y;
            s1_sin_reg    <= sin_tab[sin_idx];
            s1_cos_reg    <= cos_tab[sin_idx];
            s1_u_zero_reg <= s1_u_zero_next;
            s1_u_big_reg  <= s1_u_big_next;
            s1_v_zero_reg <= s1_v_zero_next;
            s1_v_big_reg  <= s1_v_big_next;
            s1_u_n_reg    <= DW'(nu);
            s1_v_n_reg    <= DW'(nv);
            s1_tw_reg     <= tw_eff;
            s1_th_reg     <= th_eff;
        end
    end

    logic [16:0]        tex_u, tex_v;
    logic signed [31:0] vx, vy;
    out_word_t          m_data_reg;

    sqvg_div #(.DW(DW)) u_div_u (
        .aclk    (aclk),
        .ctl     (ctl),
        .in_zero (s1_u_zero_reg),
        .in_big  (s1_u_big_reg),
        .in_n    (s1_u_n_reg),
        .in_size (s1_tw_reg),
        .coord   (tex_u)
    );

    sqvg_div #(.DW(DW)) u_div_v (
        .aclk    (aclk),
        .ctl     (ctl),
        .in_zero (s1_v_zero_reg),
        .in_big  (s1_v_big_reg),
        .in_n    (s1_v_n_reg),
        .in_size (s1_th_reg),
        .coord   (tex_v)
    );

    sqvg_xform #(.WW(WW)) u_xform (
        .aclk   (aclk),
        .ctl    (ctl),
        .in_wsx (s1_wsx_reg),
        .in_hsy (s1_hsy_reg),
        .in_gxs (s1_gxs_reg),
        .in_gys (s1_gys_reg),
        .in_px  (s1_px_reg),
        .in_py  (s1_py_reg),
        .in_sin (s1_sin_reg),
        .in_cos (s1_cos_reg),
        .vx     (vx),
        .vy     (vy)
    );

    always_ff @(posedge aclk) begin
        if (load[NST-1]) begin
            m_data_reg <= '{vertex_x: vx, vertex_y: vy, tex_u: tex_u, tex_v: tex_v,
                            vertex_index: k_reg[NST-2],
                            last_vertex: (k_reg[NST-2] == LAST_K)};
        end
    end

    assign m_valid = vld_reg[NST-1];
    assign m_data  = m_data_reg;

    `SQVG_ASSERT(a_seq_range, seq_k_reg <= LAST_K, "vertex sequencer out of range")
    `SQVG_ASSERT_NEXT(a_seq_wrap, s_valid && s_ready, seq_k_reg == FIRST_K, "sequencer did not wrap")
    `SQVG_ASSERT(a_tex_range, !m_valid || (m_data.tex_u <= TEX_ONE && m_data.tex_v <= TEX_ONE), "texture coordinate above one")
    `SQVG_ASSERT(a_last_flag, !m_valid || (m_data.last_vertex == (m_data.vertex_index == LAST_K)), "last flag mismatch")
    `SQVG_ASSERT_NEXT(a_stage_hold, vld_reg[0] && !load[0], vld_reg[0], "stalled word dropped")

endmodule

[tb/sprite_quad_vertex_generator_unit_test.sv]
// ----------------------------------------------------------------------------
// Sprite quad vertex generator testbench
// Sends sprite words with random gaps and back-pressure, predicts the six
// vertex words of each sprite in fixed point and compares every field of
// every returned word. Texture size registers are swept over zero, typical,
// the maximum and oversized values through the APB port.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator_unit_test;
    import sqvg_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [2:0] ADDR_TEX_W = 3'd0;
    localparam logic [2:0] ADDR_TEX_H = 3'd4;

    out_word_t   expected_vertices[$];
    logic [12:0] tex_w_reg;
    logic [12:0] tex_h_reg;
    int          errors;
    int          sprites_sent;
    int          vertices_checked;
    bit          no_idle;
    int          rx_stall;

    sprite_quad_vertex_generator_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #(12 * 600000);
        $display("timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint quarter_wave(input longint t);
        longint t2;
        longint acc;
        t2  = (t * t) >>> 30;
        acc = 64'sd172272;
        acc = -64'sd5026995 + ((acc * t2) >>> 30);
        acc = 64'sd85569306 + ((acc * t2) >>> 30);
        acc = -64'sd693598669 + ((acc * t2) >>> 30);
        acc = 64'sd1686629713 + ((acc * t2) >>> 30);
        acc = (acc * t) >>> 30;
        acc = (acc + 16384) >>> 15;
        if (acc > 32768) acc = 32768;
        if (acc < 0) acc = 0;
        return acc;
    endfunction

    function automatic longint eff_dim(input logic [12:0] d);
        if (d == 0) return 1;
        if (d > 4096) return 4096;
        return longint'(d);
    endfunction

    function automatic logic [16:0] texel(input longint n, input longint size);
        longint v;
        if (n <= 0) return TEX_ZERO;
        v = (n * 65536 + size / 2) / size;
        if (v > 65536) return TEX_ONE;
        return v[16:0];
    endfunction

    function automatic logic signed [31:0] clamp_pos(input longint v);
        if (v > 64'sd2147483647) return POS_MAX;
        if (v < -64'sd2147483648) return POS_MIN;
        return v[31:0];
    endfunction

    task automatic predict_quad(input in_word_t w);
        longint tw, th, rx, ry, rw, rh, sx, sy, offx, offy, sizex, sizey;
        longint sn, cs, a, b, t, idx, q, r, cx, cy, rotx, roty;
        logic [16:0] ul, ur, vt, vb, tmp;
        logic [1:0]  corner;
        out_word_t   o;
        tw = eff_dim(tex_w_reg);
        th = eff_dim(tex_h_reg);
        rx = w.src_x; ry = w.src_y; rw = w.src_w; rh = w.src_h;
        if (rx == 0 && ry == 0 && rw == 0 && rh == 0) begin
            rw = tw;
            rh = th;
        end
        sx = w.scale_x;
        sy = w.scale_y;
        sizex = rw * sx * 256;
        sizey = rh * sy * 256;
        offx = (-(longint'(w.origin_x) * sx) + 128) >>> 8;
        offy = (-(longint'(w.origin_y) * sy) + 128) >>> 8;
        ul = texel(rx + 1, tw);
        ur = texel(rx + rw - 1, tw);
        vt = texel(ry + 1, th);
        vb = texel(ry + rh - 1, th);
        if (w.orientation[0]) begin
            tmp = ul; ul = ur; ur = tmp;
        end
        if (w.orientation[1]) begin
            tmp = vt; vt = vb; vb = tmp;
        end
        idx = longint'(w.angle) >> 8;
        q = (idx * 4) / 256;
        r = idx * 4 - q * 256;
        t = (r << 30) / 256;
        a = quarter_wave(t);
        b = quarter_wave(64'sd1073741824 - t);
        case (q & 3)
            0: begin sn = a;  cs = b;  end
            1: begin sn = b;  cs = -a; end
            2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: corner = 2'd0;
                1, 4: corner = 2'd2;
                2, 3: corner = 2'd1;
                default: corner = 2'd3;
            endcase
            cx = corner[0] ? offx + sizex : offx;
            cy = corner[1] ? offy + sizey : offy;
            rotx = (cx * cs - cy * sn + 16384) >>> 15;
            roty = (cx * sn + cy * cs + 16384) >>> 15;
            o.vertex_x = clamp_pos(longint'(w.pos_x) + rotx);
            o.vertex_y = clamp_pos(longint'(w.pos_y) + roty);
            o.tex_u = corner[0] ? ur : ul;
            o.tex_v = corner[1] ? vb : vt;
            o.vertex_index = 3'(k);
            o.last_vertex = (k == 5);
            expected_vertices.insert(expected_vertices.size(), o);
        end
    endtask

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_vertices.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got %h", $time, m_data);
            end else begin
                e = expected_vertices.pop_front();
                vertices_checked++;
                check_field("vertex_x", e.vertex_x, m_data.vertex_x);
                check_field("vertex_y", e.vertex_y, m_data.vertex_y);
                check_field("tex_u", e.tex_u, m_data.tex_u);
                check_field("tex_v", e.tex_v, m_data.tex_v);
                check_field("vertex_index", e.vertex_index, m_data.vertex_index);
                check_field("last_vertex", e.last_vertex, m_data.last_vertex);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b1;
            rx_stall = 0;
        end else if (m_ready && m_valid) begin
            rx_stall = no_idle ? 0 : $urandom_range(0, 16);
            if (rx_stall > 0) m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (rx_stall > 0) rx_stall--;
            if (rx_stall == 0) m_ready <= 1'b1;
        end
    end

    task automatic send_sprite(input in_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        predict_quad(w);
        sprites_sent++;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_vertices.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [12:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_TEX_W) tex_w_reg = value;
        else tex_h_reg = value;
        @(posedge aclk);
    endtask

    task automatic set_texture(input logic [12:0] tw, input logic [12:0] th);
        drain();
        write_reg(ADDR_TEX_W, tw);
        write_reg(ADDR_TEX_H, th);
    endtask

    function automatic logic [12:0] rand_src();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'($urandom_range(0, 64));
            default: return 13'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_word_t rand_sprite();
        in_word_t w;
        w.src_x = rand_src();
        w.src_y = rand_src();
        w.src_w = rand_src();
        w.src_h = rand_src();
        if ($urandom_range(0, 7) == 0) begin
            w.src_x = 0; w.src_y = 0; w.src_w = 0; w.src_h = 0;
        end
        w.pos_x = rand_pos();
        w.pos_y = rand_pos();
        w.origin_x = rand_pos();
        w.origin_y = rand_pos();
        w.scale_x = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
        w.scale_y = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
        w.angle = 16'($urandom);
        w.orientation = 2'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic in_word_t plain_sprite(input logic [12:0] x, input logic [12:0] y,
                                              input logic [12:0] wd, input logic [12:0] ht);
        in_word_t w;
        w = '0;
        w.src_x = x; w.src_y = y; w.src_w = wd; w.src_h = ht;
        w.pos_x = 32'sh00100000;
        w.pos_y = 32'sh00200000;
        w.scale_x = 16'h0100;
        w.scale_y = 16'h0100;
        return w;
    endfunction

    task automatic test_reset_size;
        send_sprite(plain_sprite(0, 0, 0, 0));
        send_sprite(plain_sprite(0, 0, 1, 1));
    endtask

    task automatic test_extremes;
        in_word_t w;
        set_texture(13'd256, 13'd128);
        send_sprite(plain_sprite(0, 0, 0, 0));
        send_sprite(plain_sprite(13'd4096, 13'd4096, 13'd4096, 13'd4096));
        send_sprite(plain_sprite(13'd10, 13'd20, 13'd32, 13'd16));
        w = plain_sprite(13'd1, 13'd1, 13'd1, 13'd0);
        w.pos_x = POS_MAX; w.pos_y = POS_MIN;
        w.origin_x = POS_MIN; w.origin_y = POS_MAX;
        w.scale_x = 16'hffff; w.scale_y = 16'hffff;
        w.angle = 16'hffff;
        send_sprite(w);
        w.pos_x = POS_MIN; w.pos_y = POS_MAX;
        w.origin_x = POS_MAX; w.origin_y = POS_MIN;
        w.src_w = 13'd4096; w.src_h = 13'd4096;
        send_sprite(w);
        w = plain_sprite(13'd5, 13'd7, 13'd9, 13'd11);
        w.origin_x = 32'sh00048000; w.origin_y = 32'shfffb8000;
        w.scale_x = 16'h0180; w.scale_y = 16'h0001;
        for (int a = 0; a < 8; a++) begin
            w.angle = 16'(a * 8192 + 16'h00ff);
            w.orientation = 2'(a);
            send_sprite(w);
        end
    endtask

    task automatic test_flips;
        in_word_t w;
        w = plain_sprite(13'd3, 13'd4, 13'd20, 13'd30);
        for (int f = 0; f < 4; f++) begin
            w.orientation = 2'(f);
            send_sprite(w);
        end
    endtask

    task automatic test_texture_sizes;
        logic [12:0] sizes[6];
        sizes = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'h1fff, 13'd37};
        for (int i = 0; i < 6; i++) begin
            set_texture(sizes[i], sizes[5 - i]);
            send_sprite(plain_sprite(0, 0, 0, 0));
            send_sprite(plain_sprite(13'd2, 13'd3, 13'd40, 13'd50));
            send_sprite(rand_sprite());
        end
    endtask

    task automatic test_random;
        for (int p = 0; p < 5; p++) begin
            set_texture(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
            no_idle = (p == 2);
            for (int i = 0; i < 35; i++) send_sprite(rand_sprite());
            if (p == 1) drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        sprites_sent = 0;
        vertices_checked = 0;
        no_idle = 1'b0;
        tex_w_reg = 13'd1;
        tex_h_reg = 13'd1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_extremes();
        test_flips();
        test_texture_sizes();
        test_random();
        drain();
        $display("%0d sprites, %0d vertex words checked", sprites_sent, vertices_checked);
        $display("covered whole texture, flips, all quadrants, saturation, size limits");
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (expected_vertices.size() != 0)
                $display("%0t: %0d vertex words never arrived", $time, expected_vertices.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
